[sv/bmhq_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// bmhq_pkg
// Shared types and constants of the binary min-heap queue.
// ============================================================================
package bmhq_pkg;

   localparam int KEY_W        = 32;
   localparam int TAG_IN_W     = 16;
   localparam int TOTAL_W      = 9;
   localparam int STATUS_W     = 2;
   localparam int REQ_DATA_W   = 48;
   localparam int RSP_DATA_W   = 112;
   localparam int DEF_CAPACITY = 256;
   localparam int DEF_TAG_BITS = 16;

   typedef enum logic {
      OP_INSERT  = 1'b0,
      OP_EXTRACT = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_CHK,
      S_UP_CMP,
      S_EX_RD,
      S_EX_LD,
      S_DN_CHK,
      S_DN_RDR,
      S_DN_CMP,
      S_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic cap_req;
      logic rd_parent;
      logic up_move;
      logic rd_last;
      logic load_last;
      logic rd_left;
      logic rd_right;
      logic dn_move;
      logic place;
      logic load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_ext;
      logic full;
      logic empty;
      logic one_left;
      logic pos_zero;
      logic up_le;
      logic lc_ok;
      logic dn_le;
      logic rsp_free;
   } stat_type;

endpackage

[sv/binary_min_heap_queue.sv]
`timescale 1ns / 1ps
// ============================================================================
// binary_min_heap_queue
// Priority queue of (key, tag) entries held as an array-based binary min-heap.
// ============================================================================
// Each request transaction either inserts an entry (req_tuser = 0) or
// extracts the entry with the smallest signed Q16.16 key (req_tuser = 1).
// Every request yields exactly one response transaction. It carries the
// extracted entry (zeros on insert or error), the new root, the entry count
// and a status code (0 ok, 1 extract while empty, 2 insert while full). An
// erroneous request changes nothing. The entries live in a
// single-port-write, registered-read RAM of CAPACITY words, and one request
// is worked on at a time. An insert starts in the next free slot and
// climbs: each level reads the parent and, once the registered read has
// returned, compares, until the root is reached or the parent key is
// smaller. An extract moves the last entry to the root and descends: each
// level reads the left and the right child on consecutive cycles and then
// compares, until a leaf is reached or the smaller child key is larger than
// the moving one. An error, or an extract of the last entry, goes straight
// to the response. For 256 entries an insert can climb 8 levels, and an
// extract, which leaves at most 255 entries, descends at most 7 levels. The
// moving entry stays in a register and each level writes one RAM word. A
// finished response sits in an output register until taken; the next
// request is accepted once that register has been loaded, so a stalled
// response delays the next acceptance. Tags keep their low TAG_BITS bits;
// keys with equal value swap, as "less than or equal" is used.
// ============================================================================
module binary_min_heap_queue #(
   parameter int CAPACITY = bmhq_pkg::DEF_CAPACITY,
   parameter int TAG_BITS = bmhq_pkg::DEF_TAG_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: item_key [31:0], item_tag [47:32].
   input  logic [bmhq_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: opcode [0].
   input  logic                                req_tuser,
   // Response channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: out_key [31:0], out_tag [47:32], top_key [79:48], top_tag [95:80],
   // entry_total [104:96], zero fill [111:105].
   output logic [bmhq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // tuser: status [1:0].
   output logic [bmhq_pkg::STATUS_W-1:0]       rsp_tuser
);
   import bmhq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // The controller sequences the sift loops one level at a time.
   bmhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath owns the heap RAM, the count, the root copy and the
   // response register.
   bmhq_dp #(
      .CAPACITY(CAPACITY),
      .TAG_BITS(TAG_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

[sv/bmhq_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// bmhq_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module bmhq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/bmhq_ctrl.sv]
`timescale 1ns / 1ps
// ============================================================================
// bmhq_ctrl
// Sequencer for insert (sift-up) and extract (sift-down) operations.
// ============================================================================
module bmhq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  bmhq_pkg::stat_type stat,
   output bmhq_pkg::cmd_type  cmd
);
   import bmhq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.cap_req = 1'b1;
               if (stat.req_ext ? stat.empty : stat.full) begin
                  state_in = S_DONE;
               end else if (!stat.req_ext) begin
                  state_in = S_UP_CHK;
               end else if (stat.one_left) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_EX_RD;
               end
            end
         end
         S_UP_CHK: begin
            if (stat.pos_zero) begin
               cmd.place = 1'b1;
               state_in  = S_DONE;
            end else begin
               cmd.rd_parent = 1'b1;
               state_in      = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (stat.up_le) begin
               cmd.up_move = 1'b1;
               state_in    = S_UP_CHK;
            end else begin
               cmd.place = 1'b1;
               state_in  = S_DONE;
            end
         end
         S_EX_RD: begin
            cmd.rd_last = 1'b1;
            state_in    = S_EX_LD;
         end
         S_EX_LD: begin
            cmd.load_last = 1'b1;
            state_in      = S_DN_CHK;
         end
         S_DN_CHK: begin
            if (stat.lc_ok) begin
               cmd.rd_left = 1'b1;
               state_in    = S_DN_RDR;
            end else begin
               cmd.place = 1'b1;
               state_in  = S_DONE;
            end
         end
         S_DN_RDR: begin
            cmd.rd_right = 1'b1;
            state_in     = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (stat.dn_le) begin
               cmd.dn_move = 1'b1;
               state_in    = S_DN_CHK;
            end else begin
               cmd.place = 1'b1;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[sv/bmhq_dp.sv]
`timescale 1ns / 1ps
// ============================================================================
// bmhq_dp
// Heap datapath: entry store, moving entry, position, count and result.
// ============================================================================
module bmhq_dp #(
   parameter int CAPACITY = bmhq_pkg::DEF_CAPACITY,
   parameter int TAG_BITS = bmhq_pkg::DEF_TAG_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bmhq_pkg::cmd_type                   cmd,
   output bmhq_pkg::stat_type                  stat,
   input  logic                                req_tuser,
   input  logic [bmhq_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bmhq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [bmhq_pkg::STATUS_W-1:0]       rsp_tuser
);
   import bmhq_pkg::*;

   localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int IW    = AW + 2;
   localparam int TW    = (TAG_BITS < TAG_IN_W) ? TAG_BITS : TAG_IN_W;
   localparam int EW    = KEY_W + TW;
   localparam int TOT_N = (CW < TOTAL_W) ? CW : TOTAL_W;
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [EW-1:0]       mov_ff, mov_in;
   logic [EW-1:0]       left_ff, left_in;
   logic                rc_ok_ff, rc_ok_in;
   logic [EW-1:0]       top_ff, top_in;
   logic [KEY_W-1:0]    res_key_ff, res_key_in;
   logic [TW-1:0]       res_tag_ff, res_tag_in;
   status_type          res_st_ff, res_st_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0] rsp_user_ff, rsp_user_in;

   logic            wr_en, rd_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   logic [EW-1:0]   wr_data, rd_data;

   logic [IW-1:0]   pos_w, cnt_w, lc_w, rc_w;
   logic [AW-1:0]   parent_idx;
   logic            pick_right;
   logic [EW-1:0]   pick;
   logic [AW-1:0]   pick_idx;
   logic [EW-1:0]   req_entry;
   logic [EW-1:0]   top_view;
   logic [TAG_IN_W-1:0] res_tag_x, top_tag_x;
   logic [TOTAL_W-1:0]  total_x;

   bmhq_ram #(
      .WIDTH(EW),
      .DEPTH(CAPACITY)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Index arithmetic is done two bits wider than the address so that the
   // child indexes of the last slot never wrap.
   always_comb begin
      pos_w      = IW'(pos_ff);
      cnt_w      = IW'(cnt_ff);
      lc_w       = {pos_w[IW-2:0], 1'b1};
      rc_w       = lc_w + IW'(1);
      parent_idx = AW'((pos_ff - AW'(1)) >> 1);
      req_entry  = {req_tdata[KEY_W-1:0], req_tdata[KEY_W +: TW]};
      pick_right = rc_ok_ff &&
                   !($signed(left_ff[EW-1 -: KEY_W]) <= $signed(rd_data[EW-1 -: KEY_W]));
      pick       = pick_right ? rd_data : left_ff;
      pick_idx   = pick_right ? rc_w[AW-1:0] : lc_w[AW-1:0];
   end

   always_comb begin
      stat.req_ext  = (opcode_type'(req_tuser) == OP_EXTRACT);
      stat.full     = (cnt_ff == CAP_CNT);
      stat.empty    = (cnt_ff == '0);
      stat.one_left = (cnt_ff == CW'(1));
      stat.pos_zero = (pos_ff == '0);
      stat.up_le    = $signed(mov_ff[EW-1 -: KEY_W]) <= $signed(rd_data[EW-1 -: KEY_W]);
      stat.lc_ok    = (lc_w < cnt_w);
      stat.dn_le    = $signed(pick[EW-1 -: KEY_W]) <= $signed(mov_ff[EW-1 -: KEY_W]);
      stat.rsp_free = !rsp_valid_ff || rsp_tready;
   end

   // Store ports.
   always_comb begin
      wr_en   = cmd.up_move || cmd.dn_move || cmd.place;
      wr_addr = pos_ff;
      wr_data = mov_ff;
      if (cmd.up_move) begin
         wr_data = rd_data;
      end else if (cmd.dn_move) begin
         wr_data = pick;
      end
      rd_en   = cmd.rd_parent || cmd.rd_last || cmd.rd_left || cmd.rd_right;
      rd_addr = parent_idx;
      if (cmd.rd_last) begin
         rd_addr = cnt_ff[AW-1:0];
      end else if (cmd.rd_left) begin
         rd_addr = lc_w[AW-1:0];
      end else if (cmd.rd_right) begin
         rd_addr = rc_w[AW-1:0];
      end
   end

   always_comb begin
      cnt_in     = cnt_ff;
      pos_in     = pos_ff;
      mov_in     = mov_ff;
      left_in    = left_ff;
      rc_ok_in   = rc_ok_ff;
      top_in     = top_ff;
      res_key_in = res_key_ff;
      res_tag_in = res_tag_ff;
      res_st_in  = res_st_ff;

      if (cmd.cap_req) begin
         res_key_in = '0;
         res_tag_in = '0;
         res_st_in  = ST_OK;
         if (stat.req_ext) begin
            if (stat.empty) begin
               res_st_in = ST_EMPTY;
            end else begin
               res_key_in = top_ff[EW-1 -: KEY_W];
               res_tag_in = top_ff[TW-1:0];
               cnt_in     = cnt_ff - CW'(1);
            end
         end else begin
            if (stat.full) begin
               res_st_in = ST_FULL;
            end else begin
               mov_in = req_entry;
               pos_in = cnt_ff[AW-1:0];
               cnt_in = cnt_ff + CW'(1);
            end
         end
      end
      if (cmd.up_move) begin
         pos_in = parent_idx;
      end
      if (cmd.load_last) begin
         mov_in = rd_data;
         pos_in = '0;
      end
      if (cmd.rd_left) begin
         rc_ok_in = (rc_w < cnt_w);
      end
      if (cmd.rd_right) begin
         left_in = rd_data;
      end
      if (cmd.dn_move) begin
         pos_in = pick_idx;
      end
      // The root is mirrored in a register so that it is ready for the result.
      if (wr_en && (wr_addr == '0)) begin
         top_in = wr_data;
      end
   end

   // Result formatting.
   always_comb begin
      top_view  = (cnt_ff != '0) ? top_ff : '0;
      res_tag_x = '0;
      res_tag_x[TW-1:0] = res_tag_ff;
      top_tag_x = '0;
      top_tag_x[TW-1:0] = top_view[TW-1:0];
      total_x   = '0;
      total_x[TOT_N-1:0] = cnt_ff[TOT_N-1:0];

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in[KEY_W-1:0]                   = res_key_ff;
         rsp_data_in[KEY_W +: TAG_IN_W]           = res_tag_x;
         rsp_data_in[KEY_W + TAG_IN_W +: KEY_W]   = top_view[EW-1 -: KEY_W];
         rsp_data_in[2*KEY_W + TAG_IN_W +: TAG_IN_W] = top_tag_x;
         rsp_data_in[2*KEY_W + 2*TAG_IN_W +: TOTAL_W] = total_x;
         rsp_user_in  = res_st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      mov_ff      <= mov_in;
      left_ff     <= left_in;
      rc_ok_ff    <= rc_ok_in;
      top_ff      <= top_in;
      res_key_ff  <= res_key_in;
      res_tag_ff  <= res_tag_in;
      res_st_ff   <= res_st_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[verif/binary_min_heap_queue_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// binary_min_heap_queue_checker
// Passive checker that mirrors the min-heap queue and compares its responses.
// ============================================================================
module binary_min_heap_queue_checker
   import bmhq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [STATUS_W-1:0]   rsp_tuser,
   output int                    fail_count,
   output int                    pending,
   output int                    checked
);

   typedef struct {
      logic [KEY_W-1:0]    out_key;
      logic [TAG_IN_W-1:0] out_tag;
      logic [KEY_W-1:0]    top_key;
      logic [TAG_IN_W-1:0] top_tag;
      logic [TOTAL_W-1:0]  total;
      status_type          status;
   } heap_outcome_type;

   // Mirror of the heap contents; only entries below mirror_size are valid.
   logic signed [KEY_W-1:0] mirror_key [DEF_CAPACITY];
   logic [TAG_IN_W-1:0]     mirror_tag [DEF_CAPACITY];
   int                      mirror_size;
   heap_outcome_type        heap_outcomes_q [$];

   task automatic swap_slots(input int a, input int b);
      logic signed [KEY_W-1:0] k;
      logic [TAG_IN_W-1:0]     t;
      begin
         k = mirror_key[a];
         t = mirror_tag[a];
         mirror_key[a] = mirror_key[b];
         mirror_tag[a] = mirror_tag[b];
         mirror_key[b] = k;
         mirror_tag[b] = t;
      end
   endtask

   // Applies one operation to the mirror and returns what the block must answer.
   task automatic heap_apply_op(input opcode_type op, input logic signed [KEY_W-1:0] key,
                                input logic [TAG_IN_W-1:0] tag,
                                output heap_outcome_type res);
      int pos;
      int par;
      int lc;
      int pick;
      begin
         res.out_key = '0;
         res.out_tag = '0;
         res.status  = ST_OK;
         if (op == OP_INSERT) begin
            if (mirror_size >= DEF_CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               pos = mirror_size;
               mirror_key[pos] = key;
               mirror_tag[pos] = TAG_IN_W'(tag & ((1 << DEF_TAG_BITS) - 1));
               mirror_size++;
               // Equal keys still climb: the rule is child <= parent.
               while (pos > 0) begin
                  par = (pos - 1) / 2;
                  if (mirror_key[pos] > mirror_key[par]) break;
                  swap_slots(pos, par);
                  pos = par;
               end
            end
         end else begin
            if (mirror_size == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.out_key = mirror_key[0];
               res.out_tag = mirror_tag[0];
               mirror_key[0] = mirror_key[mirror_size-1];
               mirror_tag[0] = mirror_tag[mirror_size-1];
               mirror_size--;
               pos = 0;
               forever begin
                  lc = 2 * pos + 1;
                  if (lc >= mirror_size) break;
                  pick = lc;
                  if (lc + 1 < mirror_size && mirror_key[lc] > mirror_key[lc+1]) pick = lc + 1;
                  if (mirror_key[pick] > mirror_key[pos]) break;
                  swap_slots(pick, pos);
                  pos = pick;
               end
            end
         end
         res.top_key = (mirror_size > 0) ? mirror_key[0] : '0;
         res.top_tag = (mirror_size > 0) ? mirror_tag[0] : '0;
         res.total   = mirror_size[TOTAL_W-1:0];
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      begin
         if (fail_count < 40)
            $display("[%0t] mismatch on response %0d, %s: expected %h, got %h",
                     $realtime, checked, what, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      heap_outcome_type want;
      heap_outcome_type fresh;
      if (reset) begin
         mirror_size = 0;
         heap_outcomes_q.delete();
         fail_count = 0;
         checked    <= 0;
         pending    <= 0;
      end else begin
         // The response side goes first, so a request taken in the same cycle
         // can never be matched against its own response.
         if (rsp_tvalid && rsp_tready) begin
            if (heap_outcomes_q.size() == 0) begin
               report_mismatch("unexpected response", '0, rsp_tdata[63:0]);
            end else begin
               want = heap_outcomes_q.pop_front();
               if (rsp_tdata[31:0] !== want.out_key)
                  report_mismatch("out_key", 64'(want.out_key), 64'(rsp_tdata[31:0]));
               if (rsp_tdata[47:32] !== want.out_tag)
                  report_mismatch("out_tag", 64'(want.out_tag), 64'(rsp_tdata[47:32]));
               if (rsp_tdata[79:48] !== want.top_key)
                  report_mismatch("top_key", 64'(want.top_key), 64'(rsp_tdata[79:48]));
               if (rsp_tdata[95:80] !== want.top_tag)
                  report_mismatch("top_tag", 64'(want.top_tag), 64'(rsp_tdata[95:80]));
               if (rsp_tdata[104:96] !== want.total)
                  report_mismatch("entry_total", 64'(want.total), 64'(rsp_tdata[104:96]));
               if (rsp_tuser !== want.status)
                  report_mismatch("status", 64'(want.status), 64'(rsp_tuser));
            end
            checked <= checked + 1;
         end
         if (req_tvalid && req_tready) begin
            heap_apply_op(opcode_type'(req_tuser), req_tdata[31:0], req_tdata[47:32], fresh);
            heap_outcomes_q.insert(heap_outcomes_q.size(), fresh);
         end
         pending <= heap_outcomes_q.size();
      end
   end

endmodule

[verif/binary_min_heap_queue_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// binary_min_heap_queue_tb
// Stimulus and verdict for the binary min-heap priority queue.
// ============================================================================
// A short directed sequence covers an extract on an empty queue, the key and
// tag extremes and runs of equal keys. A random phase then mixes inserts and
// extracts, fills the heap to capacity and pushes further inserts into the
// full store, and drains it down to empty and beyond. Both channels stall at
// random, except for one stretch where traffic flows back to back. The
// checker module mirrors the heap and compares every response transaction.
// ============================================================================
module binary_min_heap_queue_tb;
   import bmhq_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int GAP_PERCENT    = 26;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = OP_INSERT;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;

   int  fail_count;
   int  pending;
   int  checked;
   // When set, neither side inserts idle cycles.
   logic no_gaps = 1'b0;
   // Number of entries the queue holds once all sent transactions are done.
   int  fill_level  = 0;
   int  insert_sent = 0;
   int  extract_sent = 0;
   int  full_hits   = 0;
   int  empty_hits  = 0;
   int  idle_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   binary_min_heap_queue u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   binary_min_heap_queue_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   // The receiver refuses about a quarter of the cycles, unless the
   // back-to-back stretch is active.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_gaps || ($urandom_range(0, 99) >= GAP_PERCENT);
      end
   end

   // The run ends on a long period in which neither channel moves a
   // transaction; this catches a hung block as well as a lost response.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles, %0d responses outstanding",
                     WATCHDOG_LIMIT, pending);
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Sends one request transaction, with random idle cycles ahead of it, and
   // tracks the fill level the queue will reach once it is done. The valid
   // flag is lowered only when a gap follows, so it changes at most once per
   // clock edge.
   task automatic send_item(input opcode_type op, input logic [KEY_W-1:0] key,
                            input logic [TAG_IN_W-1:0] tag);
      begin
         while (!no_gaps && $urandom_range(0, 99) < GAP_PERCENT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tuser  <= op;
         req_tdata  <= {tag, key};
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         if (op == OP_INSERT) begin
            insert_sent++;
            if (fill_level >= DEF_CAPACITY) full_hits++;
            else fill_level++;
         end else begin
            extract_sent++;
            if (fill_level == 0) empty_hits++;
            else fill_level--;
         end
      end
   endtask

   // Keys are drawn so that duplicates and the signed extremes turn up often;
   // equal keys are what exposes the ordering of the sift comparisons.
   function automatic logic [KEY_W-1:0] pick_key();
      logic [KEY_W-1:0] k;
      begin
         case ($urandom_range(0, 3))
            0: k = $urandom;
            1: k = ($urandom_range(0, 6) - 3) <<< 16;
            2: begin
               case ($urandom_range(0, 3))
                  0: k = 32'h8000_0000;
                  1: k = 32'h7FFF_FFFF;
                  2: k = 32'h0000_0000;
                  default: k = 32'hFFFF_FFFF;
               endcase
            end
            default: k = $urandom_range(0, 15) - 8;
         endcase
         pick_key = k;
      end
   endfunction

   // Random item whose operation is an insert with the given percentage.
   task automatic send_random(input int insert_percent);
      begin
         if ($urandom_range(0, 99) < insert_percent)
            send_item(OP_INSERT, pick_key(), TAG_IN_W'($urandom));
         else
            send_item(OP_EXTRACT, $urandom, TAG_IN_W'($urandom));
      end
   endtask

   initial begin
      int idx;
      int rnd_count;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part: an extract on the empty queue, the key and tag extremes,
      // equal keys with distinct tags, then a full drain and two more extracts
      // on the empty queue.
      send_item(OP_EXTRACT, 32'hFFFF_FFFF, 16'hFFFF);
      send_item(OP_INSERT, 32'h7FFF_FFFF, 16'hFFFF);
      send_item(OP_INSERT, 32'h8000_0000, 16'h0000);
      send_item(OP_INSERT, 32'h0000_0000, 16'h0001);
      send_item(OP_INSERT, 32'h0000_0000, 16'h0002);
      send_item(OP_INSERT, 32'h0000_0000, 16'h0003);
      send_item(OP_INSERT, 32'hFFFF_FFFF, 16'hAAAA);
      send_item(OP_INSERT, 32'h0000_0001, 16'h5555);
      send_item(OP_INSERT, 32'h0001_0000, 16'h1234);
      send_item(OP_INSERT, 32'h8000_0000, 16'h8000);
      for (idx = 0; idx < 10; idx++) begin
         send_item(OP_EXTRACT, 32'h0, 16'h0);
      end
      send_item(OP_EXTRACT, 32'h0, 16'h0);

      // Random phase. It wanders with balanced inserts and extracts, then
      // fills the heap to capacity and keeps inserting into the full store,
      // then drains it below empty. A stretch of the fill runs without any
      // idle cycles on either side.
      rnd_count = 0;
      for (idx = 0; idx < 20; idx++) begin
         send_random(55);
         rnd_count++;
      end
      while (full_hits < 3) begin
         no_gaps <= (rnd_count >= 60) && (rnd_count < 180);
         send_random(fill_level < DEF_CAPACITY ? 98 : 100);
         rnd_count++;
      end
      no_gaps <= 1'b0;
      while (empty_hits < 4) begin
         send_random(fill_level > 0 ? 2 : 0);
         rnd_count++;
      end
      req_tvalid <= 1'b0;

      // Let every response arrive, then give the block time to show any
      // response that should not be there.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d inserts and %0d extracts, %0d responses checked",
               insert_sent, extract_sent, checked);
      $display("inserts into a full heap: %0d, extracts from an empty heap: %0d",
               full_hits, empty_hits);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches, %0d responses missing", fail_count, pending);
         $display("tb: failure");
      end
      $finish;
   end

endmodule
